// ----- rtl/mrcp_pkg.sv -----
// ----------------------------------------------------------------------------
// mrcp_pkg
// Types and constants for the multi-row column parser.
// ----------------------------------------------------------------------------
package mrcp_pkg;

   // Parse phase of the record walker
   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_FLAG   = 4'd1,
      PH_IGNORE = 4'd2,
      PH_COUNT  = 4'd3,
      PH_SKIP   = 4'd4,
      PH_LEN    = 4'd5,
      PH_LEN_LO = 4'd6,
      PH_LEN_HI = 4'd7,
      PH_DATA   = 4'd8
   } phase_type;

   // Result event codes
   typedef enum logic [1:0] {
      EV_COL_START = 2'd0,
      EV_COL_DATA  = 2'd1,
      EV_EMPTY_ROW = 2'd2
   } event_type;

   // Input kind codes
   localparam logic KIND_OPEN = 1'b0;
   localparam logic KIND_BYTE = 1'b1;

   // Row flag bit positions
   localparam int FLAG_RID_BIT   = 3;
   localparam int FLAG_SHORT_BIT = 4;
   localparam int FLAG_NORID_BIT = 5;
   localparam int FLAG_FORCE_BIT = 6;

   // Column length byte codes
   localparam logic [7:0] LEN_NULL = 8'd255;
   localparam logic [7:0] LEN_WIDE = 8'd254;

   localparam int SKIP_W = 5;

   typedef struct packed {
      event_type   event_res;
      logic [15:0] row_index;
      logic [7:0]  column_index;
      logic [15:0] column_length;
      logic        is_null;
      logic [7:0]  data_byte;
      logic        last_in_row;
      logic        last_in_record;
   } rsp_type;

endpackage

// ----- rtl/multi_row_column_parser_unit.sv -----
// ----------------------------------------------------------------------------
// multi_row_column_parser_unit
// Byte-wise parser of packed multi-row records into column events.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one transfer per item. req_tuser is the kind: 0 opens a
//   record with the row count in req_tdata[23:8], 1 delivers one record
//   byte in req_tdata[7:0]. Bytes outside an open record are dropped.
//   rsp channel: column start (with length / null mark), column data byte,
//   or zero-column row. rsp_tlast marks the result that ends the record;
//   the end of a row travels in rsp_tdata.
//   Path: a req item is captured in the input register, its result in the
//   result register, from which it transfers on rsp. Throughput: one item
//   per cycle while rsp is not stalled; the parse state is updated by short
//   logic between the input register and the result register, so items
//   flow back to back.
//   Stall: when rsp_tready is low with a result held, the input register
//   takes one more item if it is empty and then holds; from then on
//   req_tready follows rsp_tready, and nothing is lost or repeated.
//   Reset (synchronous, active high): no record open, both stages empty,
//   all counters zero.
// ----------------------------------------------------------------------------
module multi_row_column_parser_unit
   import mrcp_pkg::*;
#(
   parameter int RID_BYTES = 6
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // byte_value[7:0], row_count[23:8]
   input  logic        req_tuser,   // kind[0]
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // row_index[15:0], column_index[23:16],
                                    // column_length[39:24], data_byte[47:40],
                                    // last_in_row[48], zero fill[55:49]
   output logic [2:0]  rsp_tuser,   // event_res[1:0], is_null[2]
   output logic        rsp_tlast    // last_in_record
);

   // Input stage
   logic        in_valid_ff, in_valid_in;
   logic        in_kind_ff;
   logic [7:0]  in_byte_ff;
   logic [15:0] in_rows_ff;

   // Parse state
   phase_type        phase_ff, phase_in;
   logic [15:0]      rows_left_ff, rows_left_in;
   logic [15:0]      row_pos_ff, row_pos_in;
   logic [7:0]       row_flag_ff, row_flag_in;
   logic [7:0]       cols_left_ff, cols_left_in;
   logic [7:0]       col_pos_ff, col_pos_in;
   logic [15:0]      bytes_left_ff, bytes_left_in;
   logic [SKIP_W-1:0] skip_left_ff, skip_left_in;
   logic [7:0]       len_low_ff, len_low_in;

   // Result stage
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    res_valid;

   logic advance;
   logic process;

   // Pipeline moves when the result register is free or being drained
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign process    = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   // Shared helper values
   logic [15:0] rows_dec, row_pos_inc, bytes_dec, hi_len;
   logic [7:0]  cols_dec, col_pos_inc, short_len;
   logic [SKIP_W-1:0] skip_dec;
   logic        has_cols, use_rid, len_null;
   phase_type   row_end_phase;

   assign rows_dec      = rows_left_ff - 16'd1;
   assign row_pos_inc   = row_pos_ff + 16'd1;
   assign cols_dec      = cols_left_ff - 8'd1;
   assign col_pos_inc   = col_pos_ff + 8'd1;
   assign bytes_dec     = bytes_left_ff - 16'd1;
   assign skip_dec      = skip_left_ff - SKIP_W'(1);
   assign hi_len        = {in_byte_ff, len_low_ff};
   assign len_null      = (in_byte_ff == LEN_NULL);
   assign short_len     = len_null ? 8'd0 : in_byte_ff;
   assign row_end_phase = (rows_dec == 16'd0) ? PH_IDLE : PH_FLAG;
   assign has_cols      = !row_flag_ff[FLAG_SHORT_BIT] || row_flag_ff[FLAG_FORCE_BIT];
   assign use_rid       = row_flag_ff[FLAG_RID_BIT] && !row_flag_ff[FLAG_NORID_BIT]
                          && (RID_BYTES > 0);

   // Next parse state
   always_comb begin
      phase_in      = phase_ff;
      rows_left_in  = rows_left_ff;
      row_pos_in    = row_pos_ff;
      row_flag_in   = row_flag_ff;
      cols_left_in  = cols_left_ff;
      col_pos_in    = col_pos_ff;
      bytes_left_in = bytes_left_ff;
      skip_left_in  = skip_left_ff;
      len_low_in    = len_low_ff;
      if (process) begin
         if (in_kind_ff == KIND_OPEN) begin
            rows_left_in  = in_rows_ff;
            row_pos_in    = 16'd0;
            row_flag_in   = 8'd0;
            cols_left_in  = 8'd0;
            col_pos_in    = 8'd0;
            bytes_left_in = 16'd0;
            skip_left_in  = '0;
            len_low_in    = 8'd0;
            phase_in      = (in_rows_ff == 16'd0) ? PH_IDLE : PH_FLAG;
         end else begin
            case (phase_ff)
               PH_IDLE: begin
                  phase_in = PH_IDLE;
               end
               PH_FLAG: begin
                  row_flag_in = in_byte_ff;
                  phase_in    = PH_IGNORE;
               end
               PH_IGNORE: begin
                  if (has_cols) begin
                     phase_in = PH_COUNT;
                  end else begin
                     row_pos_in   = row_pos_inc;
                     rows_left_in = rows_dec;
                     phase_in     = row_end_phase;
                  end
               end
               PH_COUNT: begin
                  cols_left_in = in_byte_ff;
                  col_pos_in   = 8'd0;
                  if (use_rid) begin
                     skip_left_in = SKIP_W'(RID_BYTES);
                     phase_in     = PH_SKIP;
                  end else if (in_byte_ff == 8'd0) begin
                     row_pos_in   = row_pos_inc;
                     rows_left_in = rows_dec;
                     phase_in     = row_end_phase;
                  end else begin
                     phase_in = PH_LEN;
                  end
               end
               PH_SKIP: begin
                  skip_left_in = skip_dec;
                  if (skip_dec == '0) begin
                     if (cols_left_ff == 8'd0) begin
                        row_pos_in   = row_pos_inc;
                        rows_left_in = rows_dec;
                        phase_in     = row_end_phase;
                     end else begin
                        phase_in = PH_LEN;
                     end
                  end
               end
               PH_LEN, PH_LEN_HI, PH_DATA: begin
                  // Column ends on an empty length or on its final data byte
                  if ((phase_ff == PH_LEN && in_byte_ff != LEN_WIDE && short_len == 8'd0)
                      || (phase_ff == PH_LEN_HI && hi_len == 16'd0)
                      || (phase_ff == PH_DATA && bytes_dec == 16'd0)) begin
                     col_pos_in   = col_pos_inc;
                     cols_left_in = cols_dec;
                     if (cols_dec == 8'd0) begin
                        row_pos_in   = row_pos_inc;
                        rows_left_in = rows_dec;
                        phase_in     = row_end_phase;
                     end else begin
                        phase_in = PH_LEN;
                     end
                     if (phase_ff == PH_DATA) begin
                        bytes_left_in = bytes_dec;
                     end
                  end else if (phase_ff == PH_LEN && in_byte_ff == LEN_WIDE) begin
                     phase_in = PH_LEN_LO;
                  end else if (phase_ff == PH_LEN) begin
                     bytes_left_in = {8'd0, short_len};
                     phase_in      = PH_DATA;
                  end else if (phase_ff == PH_LEN_HI) begin
                     bytes_left_in = hi_len;
                     phase_in      = PH_DATA;
                  end else begin
                     bytes_left_in = bytes_dec;
                  end
               end
               PH_LEN_LO: begin
                  len_low_in = in_byte_ff;
                  phase_in   = PH_LEN_HI;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   // Result of the current item
   always_comb begin
      res_valid = 1'b0;
      rsp_in    = '{event_res: EV_COL_START, row_index: row_pos_ff,
                    column_index: col_pos_ff, column_length: 16'd0,
                    is_null: 1'b0, data_byte: 8'd0, last_in_row: 1'b0,
                    last_in_record: 1'b0};
      if (in_kind_ff == KIND_BYTE) begin
         case (phase_ff)
            PH_COUNT, PH_SKIP: begin
               // Header done on a row with no columns
               if ((phase_ff == PH_COUNT && !use_rid && in_byte_ff == 8'd0)
                   || (phase_ff == PH_SKIP && skip_dec == '0
                       && cols_left_ff == 8'd0)) begin
                  res_valid             = 1'b1;
                  rsp_in.event_res      = EV_EMPTY_ROW;
                  rsp_in.column_index   = 8'd0;
                  rsp_in.last_in_row    = 1'b1;
                  rsp_in.last_in_record = (rows_left_ff == 16'd1);
               end
            end
            PH_LEN: begin
               if (in_byte_ff != LEN_WIDE) begin
                  res_valid             = 1'b1;
                  rsp_in.column_length  = {8'd0, short_len};
                  rsp_in.is_null        = len_null;
                  rsp_in.last_in_row    = (short_len == 8'd0) && (cols_left_ff == 8'd1);
                  rsp_in.last_in_record = (short_len == 8'd0) && (cols_left_ff == 8'd1)
                                          && (rows_left_ff == 16'd1);
               end
            end
            PH_LEN_HI: begin
               res_valid             = 1'b1;
               rsp_in.column_length  = hi_len;
               rsp_in.last_in_row    = (hi_len == 16'd0) && (cols_left_ff == 8'd1);
               rsp_in.last_in_record = (hi_len == 16'd0) && (cols_left_ff == 8'd1)
                                       && (rows_left_ff == 16'd1);
            end
            PH_DATA: begin
               res_valid             = 1'b1;
               rsp_in.event_res      = EV_COL_DATA;
               rsp_in.data_byte      = in_byte_ff;
               rsp_in.last_in_row    = (bytes_dec == 16'd0) && (cols_left_ff == 8'd1);
               rsp_in.last_in_record = (bytes_dec == 16'd0) && (cols_left_ff == 8'd1)
                                       && (rows_left_ff == 16'd1);
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

   // Stage valids: load on transfer, drop when consumed
   assign in_valid_in  = (req_tvalid && req_tready) ? 1'b1 :
                         (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = process ? res_valid :
                         (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         phase_ff      <= PH_IDLE;
         rows_left_ff  <= 16'd0;
         row_pos_ff    <= 16'd0;
         row_flag_ff   <= 8'd0;
         cols_left_ff  <= 8'd0;
         col_pos_ff    <= 8'd0;
         bytes_left_ff <= 16'd0;
         skip_left_ff  <= '0;
         len_low_ff    <= 8'd0;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         phase_ff      <= phase_in;
         rows_left_ff  <= rows_left_in;
         row_pos_ff    <= row_pos_in;
         row_flag_ff   <= row_flag_in;
         cols_left_ff  <= cols_left_in;
         col_pos_ff    <= col_pos_in;
         bytes_left_ff <= bytes_left_in;
         skip_left_ff  <= skip_left_in;
         len_low_ff    <= len_low_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_kind_ff <= req_tuser;
         in_byte_ff <= req_tdata[7:0];
         in_rows_ff <= req_tdata[23:8];
      end
      if (process && res_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.last_in_row, rsp_ff.data_byte,
                        rsp_ff.column_length, rsp_ff.column_index, rsp_ff.row_index};
   assign rsp_tuser  = {rsp_ff.is_null, rsp_ff.event_res};
   assign rsp_tlast  = rsp_ff.last_in_record;

endmodule

// ----- dv/tb_multi_row_column_parser_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_row_column_parser_unit
// Self-checking bench for the multi-row column parser. Records are streamed
// byte by byte, most of them well formed with random content, the rest cut
// short, reopened or filled with noise. A column event board walks every
// accepted transfer through its own copy of the record walker and checks each
// result transfer field by field, in order. Both sides idle and stall at
// random over several phases.
// ----------------------------------------------------------------------------
module tb_multi_row_column_parser_unit
   import mrcp_pkg::*;
();

   localparam int RID_BYTES    = 6;
   localparam int RESET_CYCLES = 9;
   localparam int ITEM_TARGET  = 1350;
   localparam int LONG_HOLD    = 300;
   localparam int IDLE_LIMIT   = 4000;
   localparam int TAIL_CYCLES  = 8;

   // -------------------------------------------------------------------------
   // Column event board: walks the record like the block and holds the
   // column events still owed by it, oldest first.
   // -------------------------------------------------------------------------
   class column_event_board;
      int          rid_bytes;
      phase_type   walk;
      logic [15:0] rows_left;
      logic [15:0] row_pos;
      logic [15:0] bytes_left;
      logic [7:0]  flag;
      logic [7:0]  cols_left;
      logic [7:0]  col_pos;
      logic [7:0]  len_low;
      logic [4:0]  skip_left;
      rsp_type     pending_events[$];
      int          mismatches;

      function new(int rid);
         rid_bytes  = rid;
         mismatches = 0;
         open_record(16'd0);
      endfunction

      // Reset looks like a record opened with no rows.
      function void open_record(logic [15:0] rows);
         rows_left  = rows;
         row_pos    = '0;
         flag       = '0;
         cols_left  = '0;
         col_pos    = '0;
         bytes_left = '0;
         skip_left  = '0;
         len_low    = '0;
         walk       = (rows == 16'd0) ? PH_IDLE : PH_FLAG;
      endfunction

      function void push_event(event_type ev, logic [15:0] len, logic nul,
                               logic [7:0] db, logic lrow, logic lrec);
         rsp_type e;
         e.event_res      = ev;
         e.row_index      = row_pos;
         e.column_index   = (ev == EV_EMPTY_ROW) ? 8'd0 : col_pos;
         e.column_length  = len;
         e.is_null        = nul;
         e.data_byte      = db;
         e.last_in_row    = lrow;
         e.last_in_record = lrec;
         pending_events.insert(pending_events.size(), e);
      endfunction

      function void close_row();
         row_pos   = row_pos + 16'd1;
         rows_left = rows_left - 16'd1;
         walk      = (rows_left == 16'd0) ? PH_IDLE : PH_FLAG;
      endfunction

      function void close_column();
         col_pos   = col_pos + 8'd1;
         cols_left = cols_left - 8'd1;
         if (cols_left == 8'd0) close_row();
         else walk = PH_LEN;
      endfunction

      // Count (and skipped bytes) done: report an empty row or go to columns.
      function void header_done();
         if (cols_left == 8'd0) begin
            push_event(EV_EMPTY_ROW, 16'd0, 1'b0, 8'd0, 1'b1, rows_left == 16'd1);
            close_row();
         end else begin
            walk = PH_LEN;
         end
      endfunction

      function void start_column(logic [15:0] len, logic nul);
         logic lrow;
         lrow = (len == 16'd0) && (cols_left == 8'd1);
         push_event(EV_COL_START, len, nul, 8'd0, lrow, lrow && (rows_left == 16'd1));
         if (len == 16'd0) begin
            close_column();
         end else begin
            bytes_left = len;
            walk       = PH_DATA;
         end
      endfunction

      function void take_item(logic kind, logic [7:0] b, logic [15:0] rows);
         logic lrow;
         if (kind == KIND_OPEN) begin
            open_record(rows);
            return;
         end
         case (walk)
            PH_FLAG: begin
               flag = b;
               walk = PH_IGNORE;
            end
            PH_IGNORE: begin
               if (!flag[FLAG_SHORT_BIT] || flag[FLAG_FORCE_BIT]) walk = PH_COUNT;
               else close_row();
            end
            PH_COUNT: begin
               cols_left = b;
               col_pos   = 8'd0;
               if (flag[FLAG_RID_BIT] && !flag[FLAG_NORID_BIT] && rid_bytes > 0) begin
                  skip_left = 5'(rid_bytes);
                  walk      = PH_SKIP;
               end else begin
                  header_done();
               end
            end
            PH_SKIP: begin
               skip_left = skip_left - 5'd1;
               if (skip_left == 5'd0) header_done();
            end
            PH_LEN: begin
               if (b == LEN_NULL) start_column(16'd0, 1'b1);
               else if (b == LEN_WIDE) walk = PH_LEN_LO;
               else start_column({8'd0, b}, 1'b0);
            end
            PH_LEN_LO: begin
               len_low = b;
               walk    = PH_LEN_HI;
            end
            PH_LEN_HI: start_column({b, len_low}, 1'b0);
            PH_DATA: begin
               bytes_left = bytes_left - 16'd1;
               lrow = (bytes_left == 16'd0) && (cols_left == 8'd1);
               push_event(EV_COL_DATA, 16'd0, 1'b0, b, lrow, lrow && (rows_left == 16'd1));
               if (bytes_left == 16'd0) close_column();
            end
            default: walk = PH_IDLE;   // no record open: drop the byte
         endcase
      endfunction

      function void report(string field, int unsigned want, int unsigned got);
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      endfunction

      function void match_event(rsp_type got);
         rsp_type want;
         if (pending_events.size() == 0) begin
            $display("%0t: result with none expected: expected nothing, actual %h",
                     $time, got);
            mismatches++;
            return;
         end
         want = pending_events.pop_front();
         if (got.event_res != want.event_res)
            report("event_res", want.event_res, got.event_res);
         if (got.row_index != want.row_index)
            report("row_index", want.row_index, got.row_index);
         if (got.column_index != want.column_index)
            report("column_index", want.column_index, got.column_index);
         if (got.column_length != want.column_length)
            report("column_length", want.column_length, got.column_length);
         if (got.is_null != want.is_null)
            report("is_null", want.is_null, got.is_null);
         if (got.data_byte != want.data_byte)
            report("data_byte", want.data_byte, got.data_byte);
         if (got.last_in_row != want.last_in_row)
            report("last_in_row", want.last_in_row, got.last_in_row);
         if (got.last_in_record != want.last_in_record)
            report("last_in_record", want.last_in_record, got.last_in_record);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals, all inputs known from time zero
   // -------------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;    // byte_value[7:0], row_count[23:8]
   logic        req_tuser  = 1'b0;  // kind[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;          // row_index, column_index, column_length,
                                    // data_byte, last_in_row, zero fill
   logic [2:0]  rsp_tuser;          // event_res[1:0], is_null[2]
   logic        rsp_tlast;          // last_in_record

   column_event_board board;
   logic [7:0]        stream_bytes[$];   // record bytes waiting to be sent
   int                req_idle_pct  = 0;
   int                rsp_stall_pct = 0;
   int                items_sent    = 0;
   int                hold_left     = 0;
   int                idle_cycles   = 0;
   bit                long_hold_req = 1'b0;

   multi_row_column_parser_unit #(
      .RID_BYTES (RID_BYTES)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Result side: check each transfer, then pick the ready for the next edge.
   // A requested long hold is counted down here, one cycle at a time.
   // -------------------------------------------------------------------------
   function automatic rsp_type rsp_fields();
      rsp_type r;
      r.event_res      = event_type'(rsp_tuser[1:0]);
      r.is_null        = rsp_tuser[2];
      r.row_index      = rsp_tdata[15:0];
      r.column_index   = rsp_tdata[23:16];
      r.column_length  = rsp_tdata[39:24];
      r.data_byte      = rsp_tdata[47:40];
      r.last_in_row    = rsp_tdata[48];
      r.last_in_record = rsp_tlast;
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.match_event(rsp_fields());
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (long_hold_req) begin
         // starve the result side so the block fills and backs up the input
         rsp_tready    <= 1'b0;
         hold_left     = LONG_HOLD;
         long_hold_req = 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Watchdog: end the run when nothing has moved for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Request side. Valid stays high after a transfer until the next call
   // drives it again in the same step, so it is never lowered and raised
   // within one step.
   // -------------------------------------------------------------------------
   task automatic send_item(input logic kind, input logic [7:0] b, input logic [15:0] rows);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {rows, b};
      do @(posedge clock); while (!req_tready);
      board.take_item(kind, b, rows);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(KIND_BYTE, b, 16'($urandom));
   endtask

   task automatic send_open(input logic [15:0] rows);
      send_item(KIND_OPEN, 8'($urandom), rows);
   endtask

   task automatic send_stream();
      while (stream_bytes.size() != 0) send_byte(stream_bytes.pop_front());
   endtask

   // Drop valid and hold the sender until every owed result has come.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending_events.size() != 0);
   endtask

   // -------------------------------------------------------------------------
   // Record builders
   // -------------------------------------------------------------------------
   function automatic void append_byte(logic [7:0] b);
      stream_bytes.insert(stream_bytes.size(), b);
   endfunction

   function automatic void add_data(int n);
      repeat (n) append_byte(8'($urandom));
   endfunction

   // Mostly short columns; no_data keeps to null and zero-length ones.
   function automatic void add_column(bit no_data);
      int pick;
      int len;
      pick = no_data ? $urandom_range(34) : $urandom_range(99);
      if (pick < 20) begin
         append_byte(LEN_NULL);
      end else if (pick < 35) begin
         append_byte(8'd0);
      end else if (pick < 75) begin
         len = $urandom_range(1, 6);
         append_byte(8'(len));
         add_data(len);
      end else if (pick < 92) begin
         len = $urandom_range(0, 9);
         append_byte(LEN_WIDE);
         append_byte(8'(len));
         append_byte(8'd0);
         add_data(len);
      end else if (pick < 96) begin
         len = $urandom_range(10, 40);
         append_byte(8'(len));
         add_data(len);
      end else if (pick < 98) begin
         len = $urandom_range(0, 255);
         append_byte(LEN_WIDE);
         append_byte(8'(len));
         append_byte(8'd0);
         add_data(len);
      end else begin
         len = $urandom_range(41, 253);
         append_byte(8'(len));
         add_data(len);
      end
   endfunction

   function automatic void add_row();
      logic [7:0] row_flag;
      int         pick;
      int         ncols;
      bit         no_data;
      row_flag = 8'($urandom);
      no_data  = 1'b0;
      append_byte(row_flag);
      append_byte(8'($urandom));
      if (!row_flag[FLAG_SHORT_BIT] || row_flag[FLAG_FORCE_BIT]) begin
         pick = $urandom_range(99);
         if (pick == 0) begin
            ncols   = $urandom_range(200, 255);
            no_data = 1'b1;
         end else if (pick < 15) begin
            ncols = 0;
         end else if (pick < 90) begin
            ncols = $urandom_range(1, 3);
         end else begin
            ncols = $urandom_range(4, 8);
         end
         append_byte(8'(ncols));
         if (row_flag[FLAG_RID_BIT] && !row_flag[FLAG_NORID_BIT]) add_data(RID_BYTES);
         repeat (ncols) add_column(no_data);
      end
   endfunction

   // One random record: mostly well formed, some cut short inside a long
   // wide column, some opened with a random row count and fed noise.
   task automatic run_record();
      int pick;
      int rows;
      pick = $urandom_range(99);
      rows = ($urandom_range(9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
      stream_bytes.delete();
      if (pick < 82) begin
         send_open(16'(rows));
         repeat (rows) add_row();
         add_data($urandom_range(2));     // trailing bytes, dropped
      end else if (pick < 90) begin
         // claim one row more and leave it inside an unfinished wide column
         send_open(16'(rows + 1));
         repeat (rows) add_row();
         append_byte(8'h00);
         append_byte(8'($urandom));
         append_byte(8'($urandom_range(1, 3)));
         append_byte(LEN_WIDE);
         append_byte(8'($urandom));
         append_byte(8'($urandom_range(1, 255)));
         add_data($urandom_range(0, 5));
      end else if (pick < 96) begin
         send_open(16'($urandom));
         add_data($urandom_range(5, 30));
      end else if (pick < 98) begin
         send_open(16'd0);
         add_data($urandom_range(1, 3));
      end else begin
         add_data($urandom_range(1, 3));
      end
      send_stream();
   endtask

   // -------------------------------------------------------------------------
   // Directed opening: dropped bytes, empty record, abandoned record, an
   // empty row, skipped id bytes, null, wide length, and a record ending on
   // a row without columns section.
   // -------------------------------------------------------------------------
   task automatic run_directed();
      send_byte(8'hA5);            // nothing open: dropped
      send_open(16'd0);            // zero rows: stays idle
      send_open(16'hFFFF);
      send_byte(8'h00);            // flag: count follows, no skip
      send_byte(8'hFF);
      send_byte(8'h00);            // zero columns: empty row event
      send_open(16'd2);            // abandon the big record
      send_byte(8'h48);            // force bit and id bit: count, then skip
      send_byte(8'h00);
      send_byte(8'h02);
      repeat (RID_BYTES) send_byte(8'h5A);
      send_byte(LEN_WIDE);
      send_byte(8'h02);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(LEN_NULL);         // null column ends the row
      send_byte(8'h10);            // short row: two bytes, no result
      send_byte(8'h33);            // record ends without a last mark
      send_byte(8'hC3);            // after the end: dropped
   endtask

   // Random part in five slices: no idling but one long result hold, sender idle,
   // receiver stalling, both idling lightly, no idling and a long hold again. Drain between slices.
   task automatic run_random();
      int base;
      int span;
      int slice;
      int last_slice;
      base       = items_sent;
      span       = ITEM_TARGET - base;
      last_slice = -1;
      while (items_sent - base < span) begin
         slice = (items_sent - base) * 5 / span;
         if (slice != last_slice) begin
            wait_for_drain();
            case (slice)
               0: begin
                  req_idle_pct  = 0;
                  rsp_stall_pct = 0;
                  long_hold_req = 1'b1;
               end
               1: begin
                  req_idle_pct  = 88;
                  rsp_stall_pct = 0;
               end
               2: begin
                  req_idle_pct  = 0;
                  rsp_stall_pct = 88;
               end
               3: begin
                  req_idle_pct  = 14;
                  rsp_stall_pct = 14;
               end
               default: begin
                  req_idle_pct  = 0;
                  rsp_stall_pct = 0;
                  long_hold_req = 1'b1;
               end
            endcase
            last_slice = slice;
         end
         run_record();
      end
   endtask

   initial begin
      board = new(RID_BYTES);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      // all stimulus in: wait for owed results, then wait out the tail
      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending_events.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
